### rtl/ple_pkg.sv
package ple_pkg;

  // Default list depth
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_DISPLAY = 2'd2,
    KIND_NONE    = 2'd3
  } ple_kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } ple_status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_CNT,
    IDX_LOAD_POS,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC
  } ple_idx_op_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_DEC,
    RD_IDX_INC,
    RD_POS
  } ple_rd_sel_e;

  typedef enum logic {
    WR_SHIFT,
    WR_NEW
  } ple_wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } ple_cnt_op_e;

  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_REMOVED,
    DATA_READ
  } ple_data_sel_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [4:0]         length;
    logic               last;
  } ple_out_t;

  // Controller to datapath
  typedef struct packed {
    logic          load_item;
    ple_idx_op_e   idx_op;
    logic          rd_en;
    ple_rd_sel_e   rd_sel;
    logic          wr_en;
    ple_wr_sel_e   wr_sel;
    ple_cnt_op_e   cnt_op;
    logic          keep_removed;
    logic          out_load;
    ple_status_e   out_status;
    ple_data_sel_e out_data;
    logic          out_last;
  } ple_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       ins_bad;
    logic       del_bad;
    logic       ins_more;
    logic       del_more;
    logic       dsp_last;
    logic       out_free;
  } ple_sts_t;

endpackage

### rtl/ple_datapath.sv
module ple_datapath import ple_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ple_in_t  in_data_i,
  input  ple_cmd_t cmd_i,
  output ple_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ple_out_t out_data_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;

  ple_in_t        item_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [31:0]    rdata_q;
  logic [31:0]    removed_q;
  logic [31:0]    mem [CAPACITY];
  logic           out_valid_q, out_valid_d;
  ple_out_t       out_q;

  logic [PW-1:0]  pos_x, cnt_x, idx_x;
  logic [AW-1:0]  pos_m1;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [31:0]    wr_data, res_data;
  logic           out_free;

  assign pos_x  = PW'(item_q.position);
  assign cnt_x  = PW'(cnt_q);
  assign idx_x  = PW'(idx_q);
  assign pos_m1 = AW'(pos_x - PW'(1));

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.kind     = item_q.kind;
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.full     = (cnt_q == CW'(CAPACITY));
  assign sts_o.ins_bad  = (pos_x == '0) || (pos_x > cnt_x + PW'(1));
  assign sts_o.del_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign sts_o.ins_more = (idx_x >= pos_x);
  assign sts_o.del_more = (idx_x + PW'(1) < cnt_x);
  assign sts_o.dsp_last = (idx_x + PW'(1) == cnt_x);
  assign sts_o.out_free = out_free;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:     rd_addr = idx_q;
      RD_IDX_DEC: rd_addr = idx_q - AW'(1);
      RD_IDX_INC: rd_addr = idx_q + AW'(1);
      RD_POS:     rd_addr = pos_m1;
    endcase
  end

  assign wr_addr = (cmd_i.wr_sel == WR_NEW) ? pos_m1 : idx_q;
  assign wr_data = (cmd_i.wr_sel == WR_NEW) ? item_q.value : rdata_q;

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_LOAD_CNT: idx_d = AW'(cnt_x);
      IDX_LOAD_POS: idx_d = pos_m1;
      IDX_CLEAR:    idx_d = '0;
      IDX_INC:      idx_d = idx_q + AW'(1);
      IDX_DEC:      idx_d = idx_q - AW'(1);
      default:      idx_d = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.out_data)
      DATA_REMOVED: res_data = removed_q;
      DATA_READ:    res_data = rdata_q;
      default:      res_data = '0;
    endcase
  end

  always_comb begin
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // List store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.keep_removed) begin
      removed_q <= rdata_q;
    end
    idx_q <= idx_d;
    if (cmd_i.out_load) begin
      out_q.status   <= cmd_i.out_status;
      out_q.data_out <= res_data;
      out_q.length   <= cnt_x[4:0];
      out_q.last     <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ple_sts_t sts_i,
  output ple_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_DSP_RD,
    S_DSP_OUT,
    S_EMIT
  } state_e;

  state_e        state_q, state_d;
  ple_status_e   res_status_q, res_status_d;
  ple_data_sel_e res_data_q, res_data_d;
  ple_cmd_t      cmd;

  always_comb begin
    cmd            = '0;
    cmd.idx_op     = IDX_HOLD;
    cmd.rd_sel     = RD_IDX;
    cmd.wr_sel     = WR_SHIFT;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_status = ST_OK;
    cmd.out_data   = DATA_ZERO;
    state_d        = state_q;
    res_status_d   = res_status_q;
    res_data_d     = res_data_q;

    unique case (state_q)
      S_IDLE: begin
        cmd.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_data_d = DATA_ZERO;
        unique case (sts_i.kind)
          KIND_INSERT: begin
            priority if (sts_i.ins_bad) begin
              res_status_d = ST_BADPOS;
              state_d      = S_EMIT;
            end else if (sts_i.full) begin
              res_status_d = ST_FULL;
              state_d      = S_EMIT;
            end else begin
              cmd.idx_op = IDX_LOAD_CNT;
              state_d    = S_INS_CHK;
            end
          end
          KIND_DELETE: begin
            priority if (sts_i.empty) begin
              res_status_d = ST_EMPTY;
              state_d      = S_EMIT;
            end else if (sts_i.del_bad) begin
              res_status_d = ST_BADPOS;
              state_d      = S_EMIT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              cmd.idx_op = IDX_LOAD_POS;
              state_d    = S_DEL_CAP;
            end
          end
          KIND_DISPLAY: begin
            if (sts_i.empty) begin
              res_status_d = ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              cmd.idx_op = IDX_CLEAR;
              state_d    = S_DSP_RD;
            end
          end
          KIND_NONE: begin
            res_status_d = ST_OK;
            state_d      = S_EMIT;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_DEC;
          state_d    = S_INS_WR;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_NEW;
          cmd.cnt_op   = CNT_INC;
          res_status_d = ST_OK;
          res_data_d   = DATA_ZERO;
          state_d      = S_EMIT;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
        state_d    = S_INS_CHK;
      end
      S_DEL_CAP: begin
        cmd.keep_removed = 1'b1;
        state_d          = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_INC;
          state_d    = S_DEL_WR;
        end else begin
          cmd.cnt_op   = CNT_DEC;
          res_status_d = ST_OK;
          res_data_d   = DATA_REMOVED;
          state_d      = S_EMIT;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_INC;
        state_d    = S_DEL_CHK;
      end
      S_DSP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_d    = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_data   = DATA_READ;
          cmd.out_last   = sts_i.dsp_last;
          if (sts_i.dsp_last) begin
            state_d = S_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_d    = S_DSP_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status_q;
          cmd.out_data   = res_data_q;
          cmd.out_last   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_OK;
      res_data_q   <= DATA_ZERO;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

endmodule

### rtl/positional_list_engine.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_data_i  (ple_in_t: kind, position, value)
// out      output     out_valid_o/out_stall_i out_data_o (ple_out_t: status, data_out,
//                                                         length, last)
//
// One transaction in at a time; in_stall_o is high from acceptance until the last
// result has been loaded into the output register.
// Every moved or shown entry costs a read then a write/emit on the list store.
// Reset clears the sequencer, the entry count and output valid; the store needs no clearing.
// Output stalls hold the result register and freeze the sequencer at its emit step.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ple_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ple_out_t out_data_o
);

  ple_cmd_t cmd;
  ple_sts_t sts;

  // Sequencer: decodes the transaction, walks the shift loop, times the results
  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // List store, count, walk index and result register
  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // Only one transaction in flight
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction active");

  // Never overwrite a result still waiting to be taken
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten under stall");

  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_op == CNT_INC) |-> !sts.full)
    else $error("insert committed on full list");

  a_no_shrink_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_op == CNT_DEC) |-> !sts.empty)
    else $error("delete committed on empty list");
`endif

endmodule

### verif/positional_list_engine_tb.sv
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int unsigned LIST_DEPTH   = CAPACITY_DEF;
  localparam int unsigned MAX_REPORTS  = 10;
  // Longest transaction is a front delete from a full list
  localparam int unsigned DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ple_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ple_out_t out_data_o;

  positional_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the list, updated as each input transaction is accepted.
  // Every answer the list should give is queued in due_results, oldest first.
  // ---------------------------------------------------------------------------
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int unsigned        shadow_len;
  ple_out_t           due_results [$];

  // Idling knobs, in percent per cycle
  int unsigned gap_pct;
  int unsigned stall_pct;
  // Long receiver hold-off, handed to the stall process which counts it down
  int unsigned hold_request;
  int unsigned hold_left;

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned items_sent;
  int unsigned kind_seen   [4];
  int unsigned status_seen [4];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reference behaviour for one accepted transaction. The list only ever
  // reads entries below shadow_len, so unwritten slots are never touched.
  task automatic apply_list_op(input ple_in_t op);
    ple_out_t           res;
    int unsigned        pos;
    int                 i;
    logic signed [31:0] removed;
    pos        = op.position;
    res        = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    kind_seen[op.kind]++;
    case (op.kind)
      KIND_INSERT: begin
        // position is vetted before fullness
        if (pos == 0 || pos > shadow_len + 1) begin
          res.status = ST_BADPOS;
        end else if (shadow_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_len; i >= int'(pos); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos-1] = op.value;
          shadow_len++;
        end
        res.length = 5'(shadow_len);
        due_results.push_back(res);
      end
      KIND_DELETE: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos == 0 || pos > shadow_len) begin
          res.status = ST_BADPOS;
        end else begin
          removed = shadow_list[pos-1];
          for (i = pos - 1; i + 1 < int'(shadow_len); i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          res.data_out = removed;
        end
        res.length = 5'(shadow_len);
        due_results.push_back(res);
      end
      KIND_DISPLAY: begin
        res.length = 5'(shadow_len);
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
          due_results.push_back(res);
        end else begin
          for (i = 0; i < int'(shadow_len); i++) begin
            res.data_out = shadow_list[i];
            res.last     = (i + 1 == int'(shadow_len));
            due_results.push_back(res);
          end
        end
      end
      default: begin
        // unused kind: harmless no-op answer
        res.length = 5'(shadow_len);
        due_results.push_back(res);
      end
    endcase
  endtask

  // Present one transaction, with an optional random idle gap before it.
  // valid is left high on return; the next call or the end of the run decides.
  task automatic send_item(input ple_in_t op);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (in_stall_o);
    apply_list_op(op);
    items_sent++;
  endtask

  function automatic ple_in_t list_op(input ple_kind_e kind, input logic [7:0] pos,
                                      input logic signed [31:0] val);
    ple_in_t op;
    op.kind     = kind;
    op.position = pos;
    op.value    = val;
    return op;
  endfunction

  // Mostly random words, with the corners thrown in now and then
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Well-formed list traffic aimed at the current length, plus some noise.
  // grow_pct steers the split between inserts and deletes.
  function automatic ple_in_t pick_item(input int unsigned grow_pct);
    ple_in_t     op;
    int unsigned roll;
    roll = $urandom_range(99);
    op   = list_op(KIND_INSERT, 8'd1, pick_value());
    if (roll < 12) begin
      op.kind     = 2'($urandom_range(3));
      op.position = 8'($urandom_range(255));
      op.value    = $urandom;
    end else if (roll < 24) begin
      op.kind     = KIND_DISPLAY;
      op.position = 8'($urandom_range(255));
    end else if ($urandom_range(99) < grow_pct) begin
      op.position = 8'($urandom_range(shadow_len + 1, 1));
    end else begin
      op.kind     = KIND_DELETE;
      op.position = (shadow_len == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(shadow_len, 1));
    end
    return op;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("MISMATCH %s: expected %0d (0x%08h) got %0d (0x%08h)",
                 name, $signed(want), want, $signed(got), got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, or a long counted hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output transaction against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    ple_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      status_seen[out_data_o.status]++;
      if (due_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("MISMATCH unexpected result: status %0d data %0d length %0d last %0d",
                   out_data_o.status, out_data_o.data_out, out_data_o.length,
                   out_data_o.last);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        report_field("status",   32'(want.status),   32'(out_data_o.status));
        report_field("data_out", want.data_out,      out_data_o.data_out);
        report_field("length",   32'(want.length),   32'(out_data_o.length));
        report_field("last",     32'(want.last),     32'(out_data_o.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Requests on an empty list that leave it empty
  task automatic test_empty_list();
    send_item(list_op(KIND_DISPLAY, 8'd0,   32'sd0));
    send_item(list_op(KIND_DELETE,  8'd1,   32'sd0));
    send_item(list_op(KIND_DELETE,  8'd0,   32'sd0));
    send_item(list_op(KIND_INSERT,  8'd0,   32'sd5));
    send_item(list_op(KIND_INSERT,  8'd2,   32'sd5));
    send_item(list_op(KIND_NONE,    8'd255, $urandom));
  endtask

  // Front, middle and back inserts and deletes, with the value corners
  task automatic test_positional_ops();
    send_item(list_op(KIND_INSERT,  8'd1,   32'sh8000_0000));
    send_item(list_op(KIND_INSERT,  8'd2,   32'sh7fff_ffff));  // append
    send_item(list_op(KIND_INSERT,  8'd1,   -32'sd1));         // new front
    send_item(list_op(KIND_INSERT,  8'd2,   32'sd0));          // middle
    send_item(list_op(KIND_NONE,    8'd255, 32'sh7fff_ffff));
    send_item(list_op(KIND_DISPLAY, 8'd255, 32'sh8000_0000));
    send_item(list_op(KIND_DELETE,  8'd0,   32'sd0));
    send_item(list_op(KIND_DELETE,  8'd5,   32'sd0));          // one past the end
    send_item(list_op(KIND_DELETE,  8'd255, 32'sd0));
    send_item(list_op(KIND_INSERT,  8'd255, $urandom));
    send_item(list_op(KIND_INSERT,  8'd6,   $urandom));        // length + 2
    send_item(list_op(KIND_INSERT,  8'd5,   32'sd77));         // length + 1
    send_item(list_op(KIND_DELETE,  8'd3,   32'sd0));          // middle
    send_item(list_op(KIND_DELETE,  8'd4,   32'sd0));          // last
    send_item(list_op(KIND_DELETE,  8'd1,   32'sd0));          // front
    send_item(list_op(KIND_DISPLAY, 8'd0,   32'sd0));
    send_item(list_op(KIND_DELETE,  8'd2,   32'sd0));
    send_item(list_op(KIND_DELETE,  8'd1,   32'sd0));
  endtask

  // Fill to capacity behind a long receiver hold-off, so the block backs up
  // and stalls its input; then the full-list cases, a full display, and empty
  // it again.
  task automatic test_full_list_backpressure();
    int unsigned n;
    hold_request = 400;
    for (n = 0; n < LIST_DEPTH; n++)
      send_item(list_op(KIND_INSERT, 8'($urandom_range(shadow_len + 1, 1)), pick_value()));
    send_item(list_op(KIND_INSERT,  8'($urandom_range(LIST_DEPTH, 1)), $urandom));
    send_item(list_op(KIND_INSERT,  8'(LIST_DEPTH + 1), $urandom));
    send_item(list_op(KIND_INSERT,  8'(LIST_DEPTH + 2), $urandom));  // bad beats full
    send_item(list_op(KIND_DISPLAY, 8'd0, 32'sd0));
    send_item(list_op(KIND_DELETE,  8'(LIST_DEPTH + 1), 32'sd0));
    while (shadow_len != 0)
      send_item(list_op(KIND_DELETE, 8'($urandom_range(shadow_len, 1)), 32'sd0));
  endtask

  // Random traffic, swinging between growing and shrinking the list so it
  // visits both full and empty
  task automatic test_random_traffic(input int unsigned count, input int unsigned gap,
                                     input int unsigned stall);
    int unsigned n;
    gap_pct   = gap;
    stall_pct = stall;
    for (n = 0; n < count; n++)
      send_item(pick_item(((n / 30) % 2 == 0) ? 75 : 25));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_data_i       <= '0;
    out_stall_i     <= 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_request    = 0;
    hold_left       = 0;
    shadow_len      = 0;
    mismatch_count  = 0;
    results_checked = 0;
    items_sent      = 0;
    for (int k = 0; k < 4; k++) begin
      kind_seen[k]   = 0;
      status_seen[k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_positional_ops();
    test_full_list_backpressure();
    test_random_traffic(102, 0,  0);
    test_random_traffic(102, 79, 0);
    test_random_traffic(102, 0,  79);
    test_random_traffic(102, 15, 15);

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (insert %0d, delete %0d, display %0d, unused %0d), %0d results",
             items_sent, kind_seen[KIND_INSERT], kind_seen[KIND_DELETE],
             kind_seen[KIND_DISPLAY], kind_seen[KIND_NONE], results_checked);
    $display("Statuses seen: ok %0d, empty %0d, bad position %0d, full %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
             status_seen[ST_FULL], mismatch_count);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung handshake or missing results end the run here
  initial begin
    #8_000_000;
    $display("Timeout with %0d results still due", due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/ple_pkg.sv
rtl/ple_datapath.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
verif/positional_list_engine_tb.sv
